>>> hw/rtl/ifta_pkg.sv
// ---------------------------------------------------------------------------
// ifta_pkg: shared types and constants for the IMU/frame time aligner
// Result kinds, command opcodes, register indexes, reset values and the sequencer state encoding.
// ---------------------------------------------------------------------------
`default_nettype none
package ifta_pkg;
    localparam int STAMP_W = 40;
    localparam int TAG_W   = 16;
    localparam int ALPHA_W = 16;

    typedef enum logic [1:0] {
        KIND_IMU    = 2'd0,
        KIND_INTERP = 2'd1,
        KIND_FRAME  = 2'd2,
        KIND_WAIT   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        OP_IMU   = 2'd0,
        OP_FRAME = 2'd1,
        OP_REQ   = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_SLOP   = 2'd1;
    localparam logic [1:0] REG_GAP    = 2'd2;
    localparam logic [1:0] REG_INTERP = 2'd3;

    localparam logic [23:0] WINDOW_RST = 24'd2000000;
    localparam logic [19:0] SLOP_RST   = 20'd20000;
    localparam logic [19:0] GAP_RST    = 20'd50000;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_IPRUNE  = 13'b0000000000010,
        S_FPRUNE  = 13'b0000000000100,
        S_RFETCH  = 13'b0000000001000,
        S_RPRUNE  = 13'b0000000010000,
        S_RCHECK  = 13'b0000000100000,
        S_WALK    = 13'b0000001000000,
        S_WALKRD  = 13'b0000010000000,
        S_DIV     = 13'b0000100000000,
        S_MIX     = 13'b0001000000000,
        S_MIXRD   = 13'b0010000000000,
        S_FRAME   = 13'b0100000000000,
        S_WAIT    = 13'b1000000000000
    } t_state;
endpackage
`default_nettype wire

>>> hw/rtl/imu_frame_time_aligner.sv
// ---------------------------------------------------------------------------
// imu_frame_time_aligner
// Buffers IMU samples and camera frames and emits aligned packets on request.
// ---------------------------------------------------------------------------
// An IMU or frame write keeps busy high while it prunes stale entries. A
// request also handles each emitted or pruned IMU sample and each dropped
// frame, and builds the interpolated beat with a 16-step alpha divider and 6
// axis multiplies; a not-ready answer comes directly or after the checks.
// One item at a time, busy high throughout; the receiver cannot stall. Reset
// (synchronous, active low) empties both FIFOs and loads register defaults;
// FIFO memory is kept.
// ---------------------------------------------------------------------------
`default_nettype none
module imu_frame_time_aligner #(
    parameter int IMU_DEPTH   = 32,
    parameter int FRAME_DEPTH = 64,
    parameter int AXIS_BITS   = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   i_opcode,
    input  wire logic [39:0]                  i_stamp,
    input  wire logic signed [AXIS_BITS-1:0]  i_accel_x,
    input  wire logic signed [AXIS_BITS-1:0]  i_accel_y,
    input  wire logic signed [AXIS_BITS-1:0]  i_accel_z,
    input  wire logic signed [AXIS_BITS-1:0]  i_gyro_x,
    input  wire logic signed [AXIS_BITS-1:0]  i_gyro_y,
    input  wire logic signed [AXIS_BITS-1:0]  i_gyro_z,
    input  wire logic [15:0]                  i_frame_tag,
    output logic                              o_strobe,
    output logic [1:0]                        o_kind,
    output logic [39:0]                       o_out_stamp,
    output logic signed [AXIS_BITS-1:0]       o_out_accel_x,
    output logic signed [AXIS_BITS-1:0]       o_out_accel_y,
    output logic signed [AXIS_BITS-1:0]       o_out_accel_z,
    output logic signed [AXIS_BITS-1:0]       o_out_gyro_x,
    output logic signed [AXIS_BITS-1:0]       o_out_gyro_y,
    output logic signed [AXIS_BITS-1:0]       o_out_gyro_z,
    output logic [15:0]                       o_out_frame_tag,
    output logic                              o_last,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [3:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    localparam int IAW = $clog2(IMU_DEPTH);
    localparam int ICW = $clog2(IMU_DEPTH + 1);
    localparam int FAW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int FCW = $clog2(FRAME_DEPTH + 1);
    localparam int AXW = 6 * AXIS_BITS;
    localparam int SW  = ifta_pkg::STAMP_W;
    localparam int PW  = AXIS_BITS + 1 + ifta_pkg::ALPHA_W + 1;

    // ---------------- configuration registers ----------------
    logic [23:0] r_window;
    logic [19:0] r_slop;
    logic [19:0] r_gap;
    logic        r_interp;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= ifta_pkg::WINDOW_RST;
            r_slop   <= ifta_pkg::SLOP_RST;
            r_gap    <= ifta_pkg::GAP_RST;
            r_interp <= 1'b1;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                ifta_pkg::REG_WINDOW: r_window <= pwdata[23:0];
                ifta_pkg::REG_SLOP:   r_slop   <= pwdata[19:0];
                ifta_pkg::REG_GAP:    r_gap    <= pwdata[19:0];
                ifta_pkg::REG_INTERP: r_interp <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            ifta_pkg::REG_WINDOW: prdata = {8'd0, r_window};
            ifta_pkg::REG_SLOP:   prdata = {12'd0, r_slop};
            ifta_pkg::REG_GAP:    prdata = {12'd0, r_gap};
            ifta_pkg::REG_INTERP: prdata = {31'd0, r_interp};
            default:              prdata = 32'd0;
        endcase
    end

    // ---------------- FIFO memories (registered reads) ----------------
    logic [SW-1:0]  imu_st_mem [IMU_DEPTH];
    logic [AXW-1:0] imu_ax_mem [IMU_DEPTH];
    logic [SW-1:0]  frm_st_mem [FRAME_DEPTH];
    logic [15:0]    frm_tg_mem [FRAME_DEPTH];

    logic           imu_we, frm_we;
    logic [IAW-1:0] imu_wa, imu_ra;
    logic [FAW-1:0] frm_wa, frm_ra;
    logic [SW-1:0]  imu_rd_st, frm_rd_st;
    logic [AXW-1:0] imu_rd_ax;
    logic [15:0]    frm_rd_tg;

    always_ff @(posedge i_clk) begin
        if (imu_we) begin
            imu_st_mem[imu_wa] <= i_stamp;
            imu_ax_mem[imu_wa] <= {i_gyro_z, i_gyro_y, i_gyro_x,
                                   i_accel_z, i_accel_y, i_accel_x};
        end
        imu_rd_st <= imu_st_mem[imu_ra];
        imu_rd_ax <= imu_ax_mem[imu_ra];
    end

    always_ff @(posedge i_clk) begin
        if (frm_we) begin
            frm_st_mem[frm_wa] <= i_stamp;
            frm_tg_mem[frm_wa] <= i_frame_tag;
        end
        frm_rd_st <= frm_st_mem[frm_ra];
        frm_rd_tg <= frm_tg_mem[frm_ra];
    end

    // ---------------- FIFO pointers ----------------
    logic [IAW-1:0] r_ihead, n_ihead;
    logic [ICW-1:0] r_icnt, n_icnt;
    logic [FAW-1:0] r_fhead, n_fhead;
    logic [FCW-1:0] r_fcnt, n_fcnt;
    logic [SW-1:0]  r_inew, n_inew;   // newest stamp of the IMU FIFO
    logic [SW-1:0]  r_fnew, n_fnew;   // stamp of the frame just written

    function automatic logic [IAW-1:0] iadd(input logic [IAW-1:0] a,
                                            input logic [ICW-1:0] b);
        logic [ICW:0] s;
        s = (ICW+1)'(a) + (ICW+1)'(b);
        if (s >= (ICW+1)'(IMU_DEPTH)) s = s - (ICW+1)'(IMU_DEPTH);
        return s[IAW-1:0];
    endfunction

    function automatic logic [FAW-1:0] fadd(input logic [FAW-1:0] a,
                                            input logic [FCW-1:0] b);
        logic [FCW:0] s;
        s = (FCW+1)'(a) + (FCW+1)'(b);
        if (s >= (FCW+1)'(FRAME_DEPTH)) s = s - (FCW+1)'(FRAME_DEPTH);
        return s[FAW-1:0];
    endfunction

    // ---------------- sequencer ----------------
    ifta_pkg::t_state r_st, n_st;
    logic [SW-1:0]  r_ft, n_ft;           // frame stamp under service
    logic [15:0]    r_ftag, n_ftag;
    logic [SW-1:0]  r_bst, n_bst;         // "before" sample
    logic [AXW-1:0] r_bax, n_bax;
    logic           r_hb, n_hb;
    logic [AXW-1:0] r_aax, n_aax;         // "after" sample axes
    // divider: numerator remainder, quotient, divisor
    logic [20:0]    r_rem, n_rem;
    logic [ifta_pkg::ALPHA_W-1:0] r_q, n_q;
    logic [19:0]    r_dt, n_dt;
    logic [4:0]     r_cnt, n_cnt;
    logic [2:0]     r_ax, n_ax;
    logic [AXW-1:0] r_mix, n_mix;
    logic           r_irf, n_irf;         // head read valid for pruning

    // output registers
    logic              n_strobe, n_last;
    logic [1:0]        n_kind;
    logic [SW-1:0]     n_ostamp;
    logic [AXW-1:0]    n_oax, r_oax;
    logic [15:0]       n_otag;

    logic [21:0]    sum_w;
    logic [SW:0]    bsum;
    logic           prune_hit;
    logic [SW-1:0]  diff;
    logic [SW-1:0]  dtw;
    logic signed [AXIS_BITS:0]   da;
    logic signed [PW-1:0]        prod;
    logic signed [PW-1:0]        qt;
    logic signed [AXIS_BITS-1:0] bsel, asel, mres;

    always_comb begin
        bsel = r_bax[r_ax*AXIS_BITS +: AXIS_BITS];
        asel = r_aax[r_ax*AXIS_BITS +: AXIS_BITS];
        da   = (AXIS_BITS+1)'(asel) - (AXIS_BITS+1)'(bsel);
        prod = PW'(da) * $signed({1'b0, r_q});
        // truncate toward zero
        qt   = (prod < 0) ? -((-prod) >>> ifta_pkg::ALPHA_W)
                          : (prod >>> ifta_pkg::ALPHA_W);
        mres = AXIS_BITS'(PW'(bsel) + qt);
    end

    always_comb begin
        n_st = r_st; n_ihead = r_ihead; n_icnt = r_icnt;
        n_fhead = r_fhead; n_fcnt = r_fcnt; n_inew = r_inew; n_fnew = r_fnew;
        n_ft = r_ft; n_ftag = r_ftag; n_bst = r_bst; n_bax = r_bax; n_hb = r_hb;
        n_aax = r_aax; n_rem = r_rem; n_q = r_q; n_dt = r_dt;
        n_cnt = r_cnt; n_ax = r_ax; n_mix = r_mix; n_irf = r_irf;
        n_strobe = 1'b0; n_last = 1'b0; n_kind = ifta_pkg::KIND_IMU;
        n_ostamp = '0; n_oax = '0; n_otag = '0;
        imu_we = 1'b0; frm_we = 1'b0;
        imu_wa = iadd(r_ihead, r_icnt); frm_wa = fadd(r_fhead, r_fcnt);
        imu_ra = r_ihead; frm_ra = r_fhead;
        sum_w = '0; bsum = '0; prune_hit = 1'b0; diff = '0; dtw = '0;
        busy = (r_st != ifta_pkg::S_IDLE);

        unique case (r_st)
            ifta_pkg::S_IDLE: begin
                if (start) begin
                    unique case (ifta_pkg::t_op'(i_opcode))
                        ifta_pkg::OP_IMU: begin
                            imu_we = 1'b1;
                            if (r_icnt == ICW'(IMU_DEPTH)) begin
                                imu_wa  = r_ihead;
                                n_ihead = iadd(r_ihead, ICW'(1));
                            end else begin
                                n_icnt = r_icnt + 1'b1;
                            end
                            n_inew = i_stamp;
                            n_irf = 1'b0;
                            n_st = ifta_pkg::S_IPRUNE;
                        end
                        ifta_pkg::OP_FRAME: begin
                            frm_we = 1'b1;
                            if (r_fcnt == FCW'(FRAME_DEPTH)) begin
                                frm_wa  = r_fhead;
                                n_fhead = fadd(r_fhead, FCW'(1));
                            end else begin
                                n_fcnt = r_fcnt + 1'b1;
                            end
                            n_fnew = i_stamp;
                            n_irf = 1'b0;
                            n_st = ifta_pkg::S_FPRUNE;
                        end
                        ifta_pkg::OP_REQ: begin
                            if (r_fcnt == '0 || r_icnt == '0) n_st = ifta_pkg::S_WAIT;
                            else n_st = ifta_pkg::S_RFETCH;
                            n_irf = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            // prune IMU head after a write: wait for the head read, then test
            ifta_pkg::S_IPRUNE: begin
                if (!r_irf || r_icnt == '0) begin
                    n_irf = (r_icnt != '0);
                    if (r_icnt == '0) n_st = ifta_pkg::S_IDLE;
                end else begin
                    diff = r_inew - imu_rd_st;
                    if (r_inew > imu_rd_st && diff > SW'(r_window)) begin
                        n_ihead = iadd(r_ihead, ICW'(1));
                        n_icnt  = r_icnt - 1'b1;
                        n_irf   = 1'b0;
                    end else begin
                        n_st = ifta_pkg::S_IDLE;
                    end
                end
            end
            ifta_pkg::S_FPRUNE: begin
                if (!r_irf) begin
                    n_irf = 1'b1;
                    if (r_fcnt <= FCW'(1)) n_st = ifta_pkg::S_IDLE;
                end else begin
                    diff = r_fnew - frm_rd_st;
                    if (r_fnew > frm_rd_st && diff > SW'(r_window)) begin
                        n_fhead = fadd(r_fhead, FCW'(1));
                        n_fcnt  = r_fcnt - 1'b1;
                        n_irf   = 1'b0;
                    end else begin
                        n_st = ifta_pkg::S_IDLE;
                    end
                end
            end
            // request: reads of frame head and IMU head land next cycle
            ifta_pkg::S_RFETCH: begin
                if (r_fcnt == '0) begin
                    n_st = ifta_pkg::S_WAIT;
                end else begin
                    n_irf = 1'b0;
                    n_st  = ifta_pkg::S_RPRUNE;
                end
            end
            ifta_pkg::S_RPRUNE: begin
                n_ft = frm_rd_st; n_ftag = frm_rd_tg;
                if (r_icnt == '0) begin
                    n_st = ifta_pkg::S_WAIT;
                end else if (r_irf) begin
                    diff = r_inew - imu_rd_st;
                    prune_hit = r_inew > imu_rd_st && diff > SW'(r_window);
                    if (prune_hit) begin
                        n_ihead = iadd(r_ihead, ICW'(1));
                        n_icnt  = r_icnt - 1'b1;
                        n_irf   = 1'b0;
                    end else begin
                        n_st = ifta_pkg::S_RCHECK;
                    end
                end else begin
                    n_irf = 1'b1;
                end
            end
            ifta_pkg::S_RCHECK: begin
                bsum = {1'b0, r_ft} + (SW+1)'(r_slop);
                if (bsum < (SW+1)'(imu_rd_st)) begin
                    n_fhead = fadd(r_fhead, FCW'(1));
                    n_fcnt  = r_fcnt - 1'b1;
                    n_st    = ifta_pkg::S_RFETCH;
                end else begin
                    bsum = {1'b0, r_inew} + (SW+1)'(r_slop);
                    if ((SW+1)'(r_ft) > bsum) begin
                        n_st = ifta_pkg::S_WAIT;
                    end else begin
                        n_hb = 1'b0;
                        n_st = ifta_pkg::S_WALK;
                    end
                end
            end
            // imu_rd_st/ax holds the current head here
            ifta_pkg::S_WALK: begin
                if (r_icnt != '0 && imu_rd_st <= r_ft) begin
                    n_bst = imu_rd_st; n_bax = imu_rd_ax; n_hb = 1'b1;
                    n_strobe = 1'b1; n_kind = ifta_pkg::KIND_IMU;
                    n_ostamp = imu_rd_st; n_oax = imu_rd_ax;
                    n_ihead = iadd(r_ihead, ICW'(1));
                    n_icnt  = r_icnt - 1'b1;
                    n_st = ifta_pkg::S_WALKRD;
                end else begin
                    n_aax = imu_rd_ax;
                    dtw = imu_rd_st - r_bst;
                    if (r_interp && r_hb && r_icnt != '0 && imu_rd_st > r_bst &&
                        dtw > SW'(1) && dtw < SW'(r_gap) && r_ft > r_bst &&
                        r_ft < imu_rd_st) begin
                        n_dt  = dtw[19:0];
                        diff  = r_ft - r_bst;
                        n_rem = {1'b0, diff[19:0]};
                        n_q   = '0;
                        n_cnt = 5'd0;
                        n_st  = ifta_pkg::S_DIV;
                    end else begin
                        n_st = ifta_pkg::S_FRAME;
                    end
                end
            end
            ifta_pkg::S_WALKRD: n_st = ifta_pkg::S_WALK;
            // restoring divider, one quotient bit a cycle: (ft-b)<<16 / dt
            ifta_pkg::S_DIV: begin
                sum_w = {r_rem, 1'b0};
                if (sum_w[21:0] >= 22'(r_dt)) begin
                    n_rem = 21'(sum_w[21:0] - 22'(r_dt));
                    n_q   = {r_q[ifta_pkg::ALPHA_W-2:0], 1'b1};
                end else begin
                    n_rem = sum_w[20:0];
                    n_q   = {r_q[ifta_pkg::ALPHA_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'(ifta_pkg::ALPHA_W - 1)) begin
                    n_ax = 3'd0;
                    n_st = ifta_pkg::S_MIX;
                end
            end
            ifta_pkg::S_MIX: begin
                n_mix[r_ax*AXIS_BITS +: AXIS_BITS] = mres;
                n_ax = r_ax + 1'b1;
                if (r_ax == 3'd5) n_st = ifta_pkg::S_MIXRD;
            end
            ifta_pkg::S_MIXRD: begin
                n_strobe = 1'b1; n_kind = ifta_pkg::KIND_INTERP;
                n_ostamp = r_ft; n_oax = r_mix;
                n_st = ifta_pkg::S_FRAME;
            end
            ifta_pkg::S_FRAME: begin
                n_strobe = 1'b1; n_kind = ifta_pkg::KIND_FRAME; n_last = 1'b1;
                n_ostamp = r_ft; n_otag = r_ftag;
                n_fhead = fadd(r_fhead, FCW'(1));
                n_fcnt  = r_fcnt - 1'b1;
                n_st = ifta_pkg::S_IDLE;
            end
            ifta_pkg::S_WAIT: begin
                n_strobe = 1'b1; n_kind = ifta_pkg::KIND_WAIT; n_last = 1'b1;
                n_st = ifta_pkg::S_IDLE;
            end
            default: n_st = ifta_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ifta_pkg::S_IDLE;
            r_ihead <= '0; r_icnt <= '0; r_fhead <= '0; r_fcnt <= '0;
            r_irf <= 1'b0; o_strobe <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ihead <= n_ihead; r_icnt <= n_icnt;
            r_fhead <= n_fhead; r_fcnt <= n_fcnt;
            r_irf <= n_irf; o_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_inew <= n_inew; r_fnew <= n_fnew; r_ft <= n_ft; r_ftag <= n_ftag;
        r_bst <= n_bst; r_bax <= n_bax; r_hb <= n_hb;
        r_aax <= n_aax; r_rem <= n_rem; r_q <= n_q; r_dt <= n_dt;
        r_cnt <= n_cnt; r_ax <= n_ax; r_mix <= n_mix;
        o_kind <= n_kind; o_out_stamp <= n_ostamp; r_oax <= n_oax;
        o_out_frame_tag <= n_otag; o_last <= n_last;
    end

    assign o_out_accel_x = r_oax[0*AXIS_BITS +: AXIS_BITS];
    assign o_out_accel_y = r_oax[1*AXIS_BITS +: AXIS_BITS];
    assign o_out_accel_z = r_oax[2*AXIS_BITS +: AXIS_BITS];
    assign o_out_gyro_x  = r_oax[3*AXIS_BITS +: AXIS_BITS];
    assign o_out_gyro_y  = r_oax[4*AXIS_BITS +: AXIS_BITS];
    assign o_out_gyro_z  = r_oax[5*AXIS_BITS +: AXIS_BITS];
endmodule
`default_nettype wire

>>> hw/rtl/ifta_checker.sv
// ---------------------------------------------------------------------------
// ifta_checker: port-level assertions for the time aligner
// Checks result framing against the command handshake.
// ---------------------------------------------------------------------------
`default_nettype none
module ifta_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_strobe,
    input wire logic [1:0] o_kind,
    input wire logic       o_last,
    input wire logic [15:0] o_out_frame_tag
);
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> (o_kind == ifta_pkg::KIND_FRAME ||
                                o_kind == ifta_pkg::KIND_WAIT))
        else $error("last on a sample result");
    a_samp_nolast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_kind == ifta_pkg::KIND_IMU || o_kind == ifta_pkg::KIND_INTERP)
        |-> !o_last && o_out_frame_tag == 16'd0)
        else $error("sample result carries last or a tag");
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("run ended without a last result");
    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> !o_strobe)
        else $error("result right after accept");
endmodule

bind imu_frame_time_aligner ifta_checker u_ifta_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_strobe(o_strobe), .o_kind(o_kind), .o_last(o_last),
    .o_out_frame_tag(o_out_frame_tag)
);
`default_nettype wire
